>>> sv/shmg_pkg.sv
// ----------------------------------------------------------------------------
// shmg_pkg: shared definitions for the shuffled minimal-standard generator
// Bus widths, generator constants and the single-step modular multiply.
// ----------------------------------------------------------------------------
package shmg_pkg;

	// stream bus widths
	localparam int S_TDATA_W = 32;
	localparam int M_TDATA_W = 64;
	localparam int WORD_W    = 31;

	// default sizing
	localparam int TABLE_SIZE_DEF   = 32;
	localparam int WARMUP_STEPS_DEF = 8;

	// generator constants
	localparam logic [14:0]       LCG_MULT = 15'd16807;
	localparam logic [WORD_W-1:0] LCG_MOD  = 31'h7FFF_FFFF;
	localparam logic [WORD_W-1:0] DEV_MAX  = 31'd2147483390;

	// opcode values carried in s_tuser
	localparam logic OP_DRAW   = 1'b0;
	localparam logic OP_RESEED = 1'b1;

	// one lehmer step: x * 16807 mod (2^31 - 1) using a mersenne fold
	function automatic logic [WORD_W-1:0] lcg_step(input logic [WORD_W-1:0] x);
		logic [45:0] prod;
		logic [31:0] fold;
		logic [31:0] red;
		prod = 46'(x) * 46'(LCG_MULT);
		fold = {1'b0, prod[30:0]} + {17'b0, prod[45:31]};
		red  = (fold >= {1'b0, LCG_MOD}) ? (fold - {1'b0, LCG_MOD}) : fold;
		return red[WORD_W-1:0];
	endfunction

endpackage

>>> sv/shuffled_minstd_generator_core.sv
// ----------------------------------------------------------------------------
// shuffled_minstd_generator_core: park-miller generator with shuffle table
// Draws uniform deviates through a bays-durham table; reseeds on request.
// ----------------------------------------------------------------------------
// Usage
//   s_* channel: one transaction per request. s_tuser is the opcode (draw or
//   reseed-then-draw), s_tdata[30:0] the seed used on reseed.
//   m_* channel: one transaction per request with the deviate and the
//   generator word.
// Processing
//   A draw passes from acceptance to m_tvalid through the step state in the
//   shared modular multiplier, where the reciprocal product for the table index
//   is registered too, then a registered table read and the write-back state.
//   A reseed, or a draw while still unseeded, adds TABLE_SIZE + WARMUP_STEPS
//   multiplier steps (40 by default) in front of the draw. s_tready is low
//   from acceptance until the result is loaded into the output register, so
//   a new draw is taken only once the previous result has been loaded.
// Reset
//   arst_n clears the generator word and the last pick; the block is then
//   unseeded and the first draw seeds with one. The table needs no clearing.
// Stall
//   A stalled result holds in the output register; the next request is
//   accepted meanwhile and its result waits in write-back until it frees.
// ----------------------------------------------------------------------------
module shuffled_minstd_generator_core #(
	parameter int TABLE_SIZE   = shmg_pkg::TABLE_SIZE_DEF,
	parameter int WARMUP_STEPS = shmg_pkg::WARMUP_STEPS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [shmg_pkg::S_TDATA_W-1:0] s_tdata,  // seed[30:0], zero pad[31]
	input  logic                           s_tuser,  // opcode[0]
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [shmg_pkg::M_TDATA_W-1:0] m_tdata   // deviate[30:0],
	                                                 // generator_word[61:31],
	                                                 // zero pad[63:62]
);
	import shmg_pkg::*;

	localparam int NSTEPS = TABLE_SIZE + WARMUP_STEPS;
	localparam int CW     = (NSTEPS > 1) ? $clog2(NSTEPS) : 1;
	localparam int IW     = $clog2(TABLE_SIZE);
	localparam int PROD_W = 2 * WORD_W;
	localparam logic [31:0] PICK_DIV =
		32'((64'(LCG_MOD) - 64'd1) / 64'(TABLE_SIZE) + 64'd1);
	// reciprocal of the pick divisor for an exact 31-bit quotient
	localparam int DIV_L = $clog2(PICK_DIV);
	localparam logic [63:0] RECIP =
		((64'd1 << WORD_W) * ((64'd1 << DIV_L) - 64'(PICK_DIV))) / 64'(PICK_DIV)
		+ 64'd1;
	localparam logic [WORD_W-1:0] RECIP_W = RECIP[WORD_W-1:0];

	// sequencer codes
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_SEED = 3'd1;
	localparam logic [2:0] ST_STEP = 3'd2;
	localparam logic [2:0] ST_READ = 3'd3;
	localparam logic [2:0] ST_DONE = 3'd4;

	logic [2:0]        state_q;
	logic [WORD_W-1:0] gen_q;
	logic [WORD_W-1:0] last_pick_q;
	logic [CW-1:0]     cnt_q;
	logic [WORD_W-1:0] rcp_q;
	logic [IW-1:0]     idx_q;
	logic [WORD_W-1:0] rd_q;
	logic              m_tvalid_q;
	logic [M_TDATA_W-1:0] m_tdata_q;

	logic [WORD_W-1:0] table_mem [TABLE_SIZE];

	logic [WORD_W-1:0] step_c;
	logic [WORD_W-1:0] seed_c;
	logic [WORD_W-1:0] dev_c;
	logic [PROD_W-1:0] rmul_c;
	logic [WORD_W-1:0] hsum_c;
	logic [WORD_W-1:0] quo_c;
	logic [IW-1:0]     idx_c;
	logic              in_acc;
	logic              out_free;
	logic              out_load;
	logic              tab_we;
	logic [IW-1:0]     tab_wa;
	logic [WORD_W-1:0] tab_wd;

	// shared modular multiplier, always fed from the generator word
	assign step_c = lcg_step(gen_q);

	// handshake
	assign s_tready = (state_q == ST_IDLE);
	assign in_acc   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;
	assign out_load = (state_q == ST_DONE) && out_free;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// seed reduction: zero and the modulus both become one
	always_comb begin
		seed_c = s_tdata[WORD_W-1:0];
		if (seed_c == '0 || seed_c == LCG_MOD) begin
			seed_c = WORD_W'(1);
		end
	end

	// table index: reciprocal product, then fix-up, shift and clamp
	assign rmul_c = PROD_W'(last_pick_q) * PROD_W'(RECIP_W);
	assign hsum_c = rcp_q + ((last_pick_q - rcp_q) >> 1);
	assign quo_c  = hsum_c >> (DIV_L - 1);
	assign idx_c  = (quo_c >= WORD_W'(TABLE_SIZE)) ? IW'(TABLE_SIZE - 1) : quo_c[IW-1:0];

	// clamped deviate
	assign dev_c = (rd_q > DEV_MAX) ? DEV_MAX : rd_q;

	// table write port: seeding fill or draw write-back
	always_comb begin
		tab_we = 1'b0;
		tab_wa = idx_q;
		tab_wd = gen_q;
		if (state_q == ST_SEED && 32'(cnt_q) < 32'(TABLE_SIZE)) begin
			tab_we = 1'b1;
			tab_wa = cnt_q[IW-1:0];
			tab_wd = step_c;
		end else if (state_q == ST_DONE && out_free) begin
			tab_we = 1'b1;
		end
	end

	// shuffle table storage
	always_ff @(posedge clk) begin
		if (tab_we) begin
			table_mem[tab_wa] <= tab_wd;
		end
		if (state_q == ST_READ) begin
			rd_q <= table_mem[idx_c];
		end
	end

	// sequencer and generator state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			gen_q       <= '0;
			last_pick_q <= '0;
			m_tvalid_q  <= 1'b0;
		end else begin
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (s_tuser == OP_RESEED) begin
							gen_q   <= seed_c;
							cnt_q   <= CW'(NSTEPS - 1);
							state_q <= ST_SEED;
						end else if (last_pick_q == '0) begin
							gen_q   <= WORD_W'(1);
							cnt_q   <= CW'(NSTEPS - 1);
							state_q <= ST_SEED;
						end else begin
							state_q <= ST_STEP;
						end
					end
				end
				ST_SEED: begin
					gen_q <= step_c;
					if (cnt_q == '0) begin
						last_pick_q <= step_c;
						state_q     <= ST_STEP;
					end else begin
						cnt_q <= cnt_q - CW'(1);
					end
				end
				ST_STEP: begin
					gen_q   <= step_c;
					rcp_q   <= rmul_c[PROD_W-1:WORD_W];
					state_q <= ST_READ;
				end
				ST_READ: begin
					idx_q   <= idx_c;
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						last_pick_q <= rd_q;
						m_tdata_q   <= {2'b00, gen_q, dev_c};
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

>>> sv/shmg_checker.sv
// ----------------------------------------------------------------------------
// shmg_checker: port-level checks for the shuffled generator core
// Watches the stream ports over time and is bound to the generator core.
// ----------------------------------------------------------------------------
module shmg_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_tvalid,
	input logic                           s_tready,
	input logic                           m_tvalid,
	input logic                           m_tready,
	input logic [shmg_pkg::M_TDATA_W-1:0] m_tdata
);
	import shmg_pkg::*;

	// a stalled result holds its value
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result changed");

	// the block is busy right after taking a transaction
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input accepted on consecutive cycles");

	// no result can appear in the cycle after a transaction is taken
	a_no_instant_result: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !$rose(m_tvalid))
		else $error("result appeared too early");

	// result fields stay in range: clamped nonzero deviate, generator word neither zero nor the modulus
	a_result_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[30:0] <= DEV_MAX) && (m_tdata[30:0] != '0)
			&& (m_tdata[61:31] != '0) && (m_tdata[61:31] != LCG_MOD))
		else $error("result field out of range");

endmodule

bind shuffled_minstd_generator_core shmg_checker u_shmg_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

>>> verif/shmg_draw_checker.sv
// ----------------------------------------------------------------------------
// shmg_draw_checker: scoreboard for the shuffled minimal-standard generator
// Watches both stream channels, predicts every draw from its own copy of the
// generator word, shuffle table and last pick, and compares each result.
// ----------------------------------------------------------------------------
module shmg_draw_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	input  logic                           s_tready,
	input  logic [shmg_pkg::S_TDATA_W-1:0] s_tdata,     // seed[30:0], zero pad[31]
	input  logic                           s_tuser,     // opcode[0]
	input  logic                           m_tvalid,
	input  logic                           m_tready,
	input  logic [shmg_pkg::M_TDATA_W-1:0] m_tdata,     // deviate[30:0],
	                                                    // generator_word[61:31],
	                                                    // zero pad[63:62]
	output int                             fail_count,
	output int                             outstanding
);
	import shmg_pkg::*;

	localparam int          NUM_SLOTS = TABLE_SIZE_DEF;
	localparam int          WARMUP    = WARMUP_STEPS_DEF;
	localparam logic [63:0] MODULUS   = 64'd2147483647;
	localparam logic [63:0] SLOT_DIV  = 64'd1 + (MODULUS - 64'd1) / NUM_SLOTS;

	// one result as it sits in m_tdata[61:0]
	typedef struct packed {
		logic [WORD_W-1:0] gen_word;
		logic [WORD_W-1:0] deviate;
	} draw_t;

	logic [WORD_W-1:0] gen_word_q  = '0;
	logic [WORD_W-1:0] prev_pick_q = '0;
	logic [WORD_W-1:0] slots [NUM_SLOTS];
	draw_t             pending_draws [$];
	int                mismatches = 0;

	// x * 16807 mod (2^31 - 1), done with a plain 64-bit remainder
	function automatic logic [WORD_W-1:0] lehmer(input logic [WORD_W-1:0] x);
		logic [63:0] prod;
		prod = ({33'd0, x} * 64'd16807) % MODULUS;
		return prod[WORD_W-1:0];
	endfunction

	// seeding: warm-up steps first, then the table fills from the top index down
	function automatic void fill_slots(input logic [WORD_W-1:0] seed);
		logic [63:0]       red;
		logic [WORD_W-1:0] x;
		int                k;
		red = {33'd0, seed} % MODULUS;
		x   = (red == 64'd0) ? 31'd1 : red[WORD_W-1:0];
		for (k = NUM_SLOTS + WARMUP - 1; k >= 0; k--) begin
			x = lehmer(x);
			if (k < NUM_SLOTS) slots[k] = x;
		end
		gen_word_q  = x;
		prev_pick_q = slots[0];
	endfunction

	// one request: optional seeding, generator step, table swap, clamp
	function automatic draw_t draw_deviate(input logic op, input logic [WORD_W-1:0] seed);
		logic [63:0]       slot;
		logic [WORD_W-1:0] pick;
		int                idx;
		draw_t             r;
		if (op == OP_RESEED) fill_slots(seed);
		else if (prev_pick_q == '0) fill_slots(31'd1);
		gen_word_q = lehmer(gen_word_q);
		slot = {33'd0, prev_pick_q} / SLOT_DIV;
		idx  = (slot >= NUM_SLOTS) ? NUM_SLOTS - 1 : int'(slot);
		pick        = slots[idx];
		slots[idx]  = gen_word_q;
		prev_pick_q = pick;
		r.deviate   = (pick > DEV_MAX) ? DEV_MAX : pick;
		r.gen_word  = gen_word_q;
		return r;
	endfunction

	// compare output transactions, then predict on input transactions
	always @(posedge clk) begin
		draw_t got;
		draw_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got = m_tdata[2*WORD_W-1:0];
				if (pending_draws.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result: deviate %0d word %0d",
							got.deviate, got.gen_word);
				end else begin
					want = pending_draws.pop_front();
					if (got.deviate !== want.deviate || got.gen_word !== want.gen_word) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: deviate exp %0d got %0d, word exp %0d got %0d",
								want.deviate, got.deviate, want.gen_word, got.gen_word);
					end
				end
			end
			if (s_tvalid && s_tready)
				pending_draws.push_back(draw_deviate(s_tuser, s_tdata[WORD_W-1:0]));
		end
		fail_count  <= mismatches;
		outstanding <= pending_draws.size();
	end

endmodule

>>> verif/tb_shuffled_minstd_generator_core.sv
// ----------------------------------------------------------------------------
// tb_shuffled_minstd_generator_core: stimulus and verdict for the generator
// Directed seeds and draws, then random traffic with planted large table
// words, under three idle patterns; the checker scores every result.
// ----------------------------------------------------------------------------
module tb_shuffled_minstd_generator_core;
	import shmg_pkg::*;

	localparam int                CYCLE_LIMIT  = 900000;
	localparam int                RANDOM_ITEMS = 1300;
	localparam int                TAIL_CYCLES  = 64;
	localparam logic [WORD_W-1:0] TOP_WORD     = 31'h7FFF_FFFF;

	logic                 clk      = 1'b0;
	logic                 arst_n   = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata  = '0;     // seed[30:0], zero pad[31]
	logic                 s_tuser  = OP_DRAW; // opcode[0]
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;           // deviate[30:0], generator_word[61:31]
	int                   fail_count;
	int                   outstanding;
	int                   send_idle_pct = 6;
	int                   recv_idle_pct = 79;
	int                   cycles = 0;

	shuffled_minstd_generator_core DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	shmg_draw_checker draw_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.fail_count  (fail_count),
		.outstanding (outstanding)
	);

	always #2 clk = ~clk;

	// receiver back-pressure
	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// seed whose generator hits target after the given number of steps,
	// so that target lands in a chosen table entry during seeding
	function automatic logic [WORD_W-1:0] planted_seed(input logic [WORD_W-1:0] target,
		input int steps);
		logic [63:0] inv;
		logic [63:0] base;
		logic [63:0] acc;
		logic [31:0] e;
		int          n;
		// 16807^-1 by fermat: 16807^(p-2)
		inv  = 64'd1;
		base = 64'd16807;
		e    = 32'd2147483645;
		while (e != 0) begin
			if (e[0]) inv = (inv * base) % 64'd2147483647;
			base = (base * base) % 64'd2147483647;
			e    = e >> 1;
		end
		acc = {33'd0, target};
		for (n = 0; n < steps; n++) acc = (acc * inv) % 64'd2147483647;
		return acc[WORD_W-1:0];
	endfunction

	// one input transaction with optional leading idle cycles
	task automatic send_request(input logic op, input logic [WORD_W-1:0] seed);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {1'b0, seed};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	// mostly draws, with occasional reseeds of every flavor
	task automatic run_phase(input int send_pct, input int recv_pct, input int count);
		logic [WORD_W-1:0] seed;
		int                i;
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		for (i = 0; i < count; i++) begin
			seed = WORD_W'($urandom());
			if ($urandom_range(15) == 0) begin
				case ($urandom_range(7))
					0: seed = '0;
					1: seed = TOP_WORD;
					2, 3: seed = planted_seed(WORD_W'($urandom_range(2147483646, 2147483386)),
						$urandom_range(WARMUP_STEPS_DEF + TABLE_SIZE_DEF, WARMUP_STEPS_DEF + 1));
					default: ;
				endcase
				send_request(OP_RESEED, seed);
			end else begin
				send_request(OP_DRAW, seed);
			end
		end
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// draw while unseeded seeds with one
		send_request(OP_DRAW, TOP_WORD);
		send_request(OP_DRAW, '0);
		// zero seed and seed equal to the modulus both act as one
		send_request(OP_RESEED, '0);
		send_request(OP_DRAW, TOP_WORD);
		send_request(OP_RESEED, TOP_WORD);
		send_request(OP_RESEED, 31'd1);
		send_request(OP_RESEED, 31'h7FFF_FFFE);
		send_request(OP_DRAW, 31'h5555_5555);
		send_request(OP_RESEED, 31'h2AAA_AAAA);
		// plant the largest word in the table, then draw so it saturates when picked
		send_request(OP_RESEED, planted_seed(31'h7FFF_FFFE, WARMUP_STEPS_DEF + 1));
		repeat (15) send_request(OP_DRAW, WORD_W'($urandom()));

		run_phase(6, 79, RANDOM_ITEMS / 3);
		run_phase(79, 6, RANDOM_ITEMS / 3);
		run_phase(0, 0, RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3));
		s_tvalid <= 1'b0;

		// drain, then give any stray result time to show up
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0 && outstanding == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

>>> files.f
sv/shmg_pkg.sv
sv/shuffled_minstd_generator_core.sv
sv/shmg_checker.sv
verif/shmg_draw_checker.sv
verif/tb_shuffled_minstd_generator_core.sv
